// File: design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MVD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MVD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/mvd_pkg.sv
// Package with types, constants and binary32 helpers for the vertex welding table.
package mvd_pkg;

    localparam int CAPACITY = 4096;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;

    // binary32(2/65535) and the default NaN that an invalid multiply returns.
    localparam logic [31:0] SCALE_BITS  = 32'h3800_0080;
    localparam logic [31:0] NAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] EDGE_RESET  = 32'h3F80_0000;

    localparam logic CFG_EDGE      = 1'b0;
    localparam logic CFG_CHECK_ALL = 1'b1;

    typedef struct packed {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        pos_z;
        logic signed [31:0] block_x;
        logic signed [31:0] block_y;
        logic signed [31:0] block_z;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               block_start;
    } in_t;

    typedef struct packed {
        logic [11:0] vert_index;
        logic        is_new;
        logic [31:0] coord_x_bits;
        logic [31:0] coord_y_bits;
        logic [31:0] coord_z_bits;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        triangle_done;
        logic [11:0] corner_a;
        logic [11:0] corner_b;
        logic        table_full;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       conv;
        logic       mul1;
        logic       add;
        logic       mul2;
        logic [1:0] axis;
        logic       search_init;
        logic       search;
        logic       write;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic out_busy;
    } status_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                lz = 6'(47 - i);
            end
        end
        return lz;
    endfunction

    // Round to nearest even and pack. Value is sig / 2^26 * 2^(e - 127),
    // with sig[26] set unless the value is subnormal or zero.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [26:0] sig);
        logic [26:0] sg;
        logic [7:0]  ef;
        logic [11:0] sh;
        logic        g;
        logic        st;
        logic        up;
        logic [31:0] r;
        sg = sig;
        ef = 8'd0;
        sh = 12'd0;
        if (sig == 27'd0)
        begin
            r = {s, 31'd0};
        end
        else if (e >= 12'sd255)
        begin
            r = {s, 8'hFF, 23'd0};
        end
        else
        begin
            if (e <= 12'sd0)
            begin
                sh = 12'(12'sd1 - e);
                if (sh >= 12'd27)
                begin
                    sg = 27'd1;
                end
                else
                begin
                    sg = (sig >> sh) | {26'd0, |(sig & ((27'd1 << sh) - 27'd1))};
                end
                ef = 8'd0;
            end
            else
            begin
                ef = e[7:0];
            end
            g  = sg[2];
            st = |sg[1:0];
            up = g & (st | sg[3]);
            r  = {s, ef, sg[25:3]} + {31'd0, up};
        end
        return r;
    endfunction

    function automatic logic [31:0] int_to_float(input logic [31:0] v);
        logic        s;
        logic [31:0] mag;
        logic [5:0]  lz;
        logic [31:0] n;
        logic signed [11:0] e;
        s   = v[31];
        mag = s ? (32'd0 - v) : v;
        lz  = lzc48({mag, 16'd0});
        n   = mag << lz;
        e   = 12'sd158 - $signed({6'd0, lz});
        return round_pack(s, e, n[31:5] | {26'd0, |n[4:0]});
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        logic [5:0]  lz;
        logic [47:0] pn;
        logic signed [11:0] e;
        logic [31:0] r;
        s  = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = ma * mb;
        lz = lzc48(p);
        pn = p << lz;
        e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - $signed({6'd0, lz}) - 12'sd126;
        if (is_nan(a))
        begin
            r = a | 32'h0040_0000;
        end
        else if (is_nan(b))
        begin
            r = b | 32'h0040_0000;
        end
        else if ((is_inf(a) && (b[30:0] == 31'd0)) || (is_inf(b) && (a[30:0] == 31'd0)))
        begin
            r = NAN_DEFAULT;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            r = {s, 8'hFF, 23'd0};
        end
        else if (p == 48'd0)
        begin
            r = {s, 31'd0};
        end
        else
        begin
            r = round_pack(s, e, pn[47:21] | {26'd0, |pn[20:0]});
        end
        return r;
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [26:0] av;
        logic [26:0] bv;
        logic [26:0] bal;
        logic [27:0] sum;
        logic [5:0]  lz;
        logic [26:0] sig;
        logic signed [11:0] e;
        logic [31:0] r;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        av  = {big[30:23] != 8'd0, big[22:0], 3'd0};
        bv  = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        if (d >= 8'd27)
        begin
            bal = {26'd0, |bv};
        end
        else
        begin
            bal = (bv >> d) | {26'd0, |(bv & ((27'd1 << d) - 27'd1))};
        end
        if (big[31] ^ sml[31])
        begin
            sum = {1'b0, av} - {1'b0, bal};
        end
        else
        begin
            sum = {1'b0, av} + {1'b0, bal};
        end
        lz  = lzc48({sum[26:0], 21'd0});
        sig = 27'd0;
        e   = 12'sd0;
        if (sum[27])
        begin
            sig = sum[27:1] | {26'd0, sum[0]};
            e   = $signed({4'd0, eb}) + 12'sd1;
        end
        else
        begin
            sig = sum[26:0] << lz;
            e   = $signed({4'd0, eb}) - $signed({6'd0, lz});
        end
        if (is_nan(a))
        begin
            r = a | 32'h0040_0000;
        end
        else if (is_nan(b))
        begin
            r = b | 32'h0040_0000;
        end
        else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
        begin
            r = NAN_DEFAULT;
        end
        else if (is_inf(a))
        begin
            r = a;
        end
        else if (is_inf(b))
        begin
            r = b;
        end
        else if (sum == 28'd0)
        begin
            r = {a[31] & b[31], 31'd0};
        end
        else
        begin
            r = round_pack(big[31], e, sig);
        end
        return r;
    endfunction

    // binary32 equality: NaN never equal, signed zeros equal.
    function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
        return !is_nan(a) && !is_nan(b) && ((a == b) || (((a | b) & 32'h7FFF_FFFF) == 32'd0));
    endfunction

endpackage

// File: design/mvd_ctrl.sv
// Controller state machine that sequences conversion, search and update.
module mvd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mvd_pkg::status_t status,
    output mvd_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CONV   = 4'd1;
    localparam logic [3:0] ST_MUL1   = 4'd2;
    localparam logic [3:0] ST_ADD    = 4'd3;
    localparam logic [3:0] ST_MUL2   = 4'd4;
    localparam logic [3:0] ST_SINIT  = 4'd5;
    localparam logic [3:0] ST_SEARCH = 4'd6;
    localparam logic [3:0] ST_WAIT   = 4'd7;
    localparam logic [3:0] ST_WRITE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = 2'd0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2 = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_SINIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_CONV;
                end
            end
            ST_SINIT:
            begin
                cmd.search_init = 1'b1;
                state_next      = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    cmd.search = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// File: design/mvd_datapath.sv
// Datapath: float arithmetic, vertex tables, search pointer and result register.
module mvd_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  mvd_pkg::cmd_t    cmd,
    output mvd_pkg::status_t status,
    input  mvd_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mvd_pkg::out_t    out_data,
    input  logic             cfg_valid,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);

    logic [95:0] coord_mem  [mvd_pkg::CAPACITY];
    logic [23:0] colour_mem [mvd_pkg::CAPACITY];

    logic [31:0] edge_reg;
    logic        check_all_reg;
    mvd_pkg::in_t in_reg;
    logic [31:0] qf_reg;
    logic [31:0] idxf_reg;
    logic [31:0] acc_reg;
    logic [31:0] cx_reg;
    logic [31:0] cy_reg;
    logic [31:0] cz_reg;
    logic [95:0] rd_reg;
    logic [mvd_pkg::CNT_W-1:0] count_reg;
    logic [mvd_pkg::CNT_W-1:0] base_reg;
    logic [mvd_pkg::CNT_W-1:0] rd_k_reg;
    logic [mvd_pkg::IDX_W-1:0] cmp_k_reg;
    logic [mvd_pkg::IDX_W-1:0] hit_idx_reg;
    logic        rd_valid_reg;
    logic        found_reg;
    logic [1:0]  corner_cnt_reg;
    logic [11:0] first_reg;
    logic [11:0] second_reg;
    logic        out_valid_reg;
    mvd_pkg::out_t out_reg;

    logic [15:0] q_sel;
    logic [31:0] blk_sel;
    logic        hit;
    logic        room;
    logic [mvd_pkg::IDX_W-1:0] widx;
    logic [11:0] vidx;
    mvd_pkg::out_t res;

    always_comb
    begin
        case (cmd.axis)
            2'd0:
            begin
                q_sel   = in_reg.pos_x;
                blk_sel = in_reg.block_x;
            end
            2'd1:
            begin
                q_sel   = in_reg.pos_y;
                blk_sel = in_reg.block_y;
            end
            default:
            begin
                q_sel   = in_reg.pos_z;
                blk_sel = in_reg.block_z;
            end
        endcase
    end

    assign hit = rd_valid_reg && !found_reg
              && mvd_pkg::feq(rd_reg[95:64], cx_reg)
              && mvd_pkg::feq(rd_reg[63:32], cy_reg)
              && mvd_pkg::feq(rd_reg[31:0], cz_reg);

    assign status.search_done = found_reg || (!rd_valid_reg && (rd_k_reg >= count_reg));
    assign status.out_busy    = out_valid_reg;

    assign room = count_reg < mvd_pkg::CNT_W'(mvd_pkg::CAPACITY);
    assign widx = found_reg ? hit_idx_reg : count_reg[mvd_pkg::IDX_W-1:0];
    assign vidx = found_reg ? 12'(hit_idx_reg)
                : (room ? 12'(count_reg[mvd_pkg::IDX_W-1:0]) : 12'd0);

    always_comb
    begin
        res               = '0;
        res.vert_index    = vidx;
        res.is_new        = !found_reg && room;
        res.coord_x_bits  = cx_reg;
        res.coord_y_bits  = cy_reg;
        res.coord_z_bits  = cz_reg;
        res.red_out       = in_reg.red;
        res.green_out     = in_reg.green;
        res.blue_out      = in_reg.blue;
        res.table_full    = !found_reg && !room;
        if (corner_cnt_reg == 2'd2)
        begin
            res.triangle_done = 1'b1;
            res.corner_a      = first_reg;
            res.corner_b      = second_reg;
        end
    end

    // Tables: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write && (found_reg || room))
        begin
            coord_mem[widx]  <= {cx_reg, cy_reg, cz_reg};
            colour_mem[widx] <= {in_reg.red, in_reg.green, in_reg.blue};
        end
        if (cmd.search)
        begin
            rd_reg <= coord_mem[rd_k_reg[mvd_pkg::IDX_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.conv)
        begin
            qf_reg   <= mvd_pkg::int_to_float({16'd0, q_sel});
            idxf_reg <= mvd_pkg::int_to_float(blk_sel);
        end
        if (cmd.mul1)
        begin
            acc_reg <= mvd_pkg::fmul(qf_reg, mvd_pkg::SCALE_BITS);
        end
        if (cmd.add)
        begin
            acc_reg <= mvd_pkg::fadd(acc_reg, idxf_reg);
        end
        if (cmd.mul2)
        begin
            case (cmd.axis)
                2'd0:    cx_reg <= mvd_pkg::fmul(acc_reg, edge_reg);
                2'd1:    cy_reg <= mvd_pkg::fmul(acc_reg, edge_reg);
                default: cz_reg <= mvd_pkg::fmul(acc_reg, edge_reg);
            endcase
        end
        if (cmd.search)
        begin
            cmp_k_reg <= rd_k_reg[mvd_pkg::IDX_W-1:0];
        end
        if (hit)
        begin
            hit_idx_reg <= cmp_k_reg;
        end
        if (cmd.write)
        begin
            out_reg <= res;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg       <= mvd_pkg::EDGE_RESET;
            check_all_reg  <= 1'b0;
            count_reg      <= '0;
            base_reg       <= '0;
            rd_k_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            corner_cnt_reg <= 2'd0;
            first_reg      <= 12'd0;
            second_reg     <= 12'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == mvd_pkg::CFG_EDGE)
                begin
                    edge_reg <= cfg_data;
                end
                else
                begin
                    check_all_reg <= cfg_data[0];
                end
            end
            if (cmd.load && in_data.block_start)
            begin
                corner_cnt_reg <= 2'd0;
                base_reg       <= check_all_reg ? '0 : count_reg;
            end
            if (cmd.search_init)
            begin
                rd_k_reg     <= base_reg;
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            if (cmd.search)
            begin
                if (hit)
                begin
                    found_reg    <= 1'b1;
                    rd_valid_reg <= 1'b0;
                end
                else if (rd_k_reg < count_reg)
                begin
                    rd_valid_reg <= 1'b1;
                    rd_k_reg     <= rd_k_reg + 1'b1;
                end
                else
                begin
                    rd_valid_reg <= 1'b0;
                end
            end
            if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
                if (!found_reg && room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                case (corner_cnt_reg)
                    2'd0:
                    begin
                        first_reg      <= vidx;
                        corner_cnt_reg <= 2'd1;
                    end
                    2'd1:
                    begin
                        second_reg     <= vidx;
                        corner_cnt_reg <= 2'd2;
                    end
                    default:
                    begin
                        corner_cnt_reg <= 2'd0;
                    end
                endcase
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: design/mesh_vertex_dedup_table.sv
// Top level of the mesh vertex welding table.
// Each request carries one quantized vertex, its block index and a color. The block
// forms binary32 coordinates (q * binary32(2/65535) + index) * edge, each operation
// rounded to nearest even, then searches the stored vertices for an equal one, one
// table entry per clock from a registered read port. A hit overwrites the entry
// and reports its index; a miss appends the vertex, or reports a full table. Every
// third vertex after a block start closes a triangle. One request is in work at a
// time: it is accepted, then float conversion, multiply, add and multiply run in
// four steps per axis, a search setup follows, then the search over the entries
// between the search base and the fill count, a check of the output register and
// the update; a full table holds 4096 entries. The finished result sits in an output
// register and the next request is taken while it waits; it is only held back if it
// finishes before the previous result has been taken. The tables need no clearing pass:
// only entries below the fill count are ever compared. Configuration writes are always
// accepted and must only be issued while the block is idle.
module mesh_vertex_dedup_table
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mvd_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mvd_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    mvd_pkg::cmd_t    cmd;
    mvd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mvd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mvd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: design/mvd_checker.sv
// Port-level checker for the vertex welding table and its bind.
`include "assert_macros.svh"

module mvd_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input mvd_pkg::out_t out_data
);

    // A stalled result keeps its value.
    `MVD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // Only one request is in work, so the block is busy right after taking one.
    `MVD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A full table reports index zero and nothing appended.
    `MVD_ASSERT_IMP(a_full_result, out_valid && out_data.table_full,
                    !out_data.is_new && (out_data.vert_index == 12'd0))
    // Corners are zero unless a triangle is closed.
    `MVD_ASSERT_IMP(a_no_triangle, out_valid && !out_data.triangle_done,
                    (out_data.corner_a == 12'd0) && (out_data.corner_b == 12'd0))

endmodule

bind mesh_vertex_dedup_table mvd_checker u_mvd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
